/* rtl/core/lsa_pkg.sv */
// lsa_pkg: widths, request and outcome codes and the compare result type
// shared by the slot allocator, its channel interfaces and its compare unit
// no dependencies
package lsa_pkg;

   localparam int OP_W      = 2;
   localparam int ID_W      = 31;
   localparam int SLOT_W    = 4;
   localparam int OUTCOME_W = 3;
   localparam int STAMP_W   = 64;

   // request kinds
   localparam logic [OP_W-1:0] OP_ASSIGN  = 2'd0;
   localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

   // response outcomes
   localparam logic [OUTCOME_W-1:0] OUT_HIT          = 3'd0;
   localparam logic [OUTCOME_W-1:0] OUT_FILLED       = 3'd1;
   localparam logic [OUTCOME_W-1:0] OUT_EVICTED      = 3'd2;
   localparam logic [OUTCOME_W-1:0] OUT_RELEASED     = 3'd3;
   localparam logic [OUTCOME_W-1:0] OUT_RELEASE_MISS = 3'd4;
   localparam logic [OUTCOME_W-1:0] OUT_CLEARED      = 3'd5;

   typedef struct packed {
      logic id_match;   // entry owner equals the request id
      logic older;      // entry stamp below the oldest seen so far
   } cmp_res_type;

endpackage

/* rtl/core/lsa_if.sv */
// lsa_if: valid/ready channel interfaces for requests and responses
// depends on lsa_pkg
interface lsa_req_if import lsa_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [OP_W-1:0] op;
   logic [ID_W-1:0] buffer_id;

   modport source (output valid, output op, output buffer_id, input ready);
   modport sink   (input valid, input op, input buffer_id, output ready);
endinterface

interface lsa_rsp_if import lsa_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [SLOT_W-1:0]    slot;
   logic [OUTCOME_W-1:0] outcome;
   logic [ID_W-1:0]      evicted_id;

   modport source (output valid, output slot, output outcome, output evicted_id,
                   input ready);
   modport sink   (input valid, input slot, input outcome, input evicted_id,
                   output ready);
endinterface

/* rtl/core/lsa_ram.sv */
// lsa_ram: slot table store, one write port and one registered read port
// no package dependencies
module lsa_ram #(
   parameter int WIDTH = 95,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/lsa_cmp.sv */
// lsa_cmp: shared compare unit used once per scanned slot
// depends on lsa_pkg
module lsa_cmp import lsa_pkg::*; (
   input  logic [ID_W-1:0]    entry_owner,
   input  logic [STAMP_W-1:0] entry_stamp,
   input  logic [ID_W-1:0]    key_id,
   input  logic [STAMP_W-1:0] best_stamp,
   output cmp_res_type        res
);

   always_comb begin
      res.id_match = (entry_owner == key_id);
      res.older    = (entry_stamp < best_stamp);
   end

endmodule

/* rtl/core/lru_slot_allocator.sv */
// lru_slot_allocator: fully associative id-to-slot table with lru replacement
// depends on lsa_pkg, lsa_if, lsa_ram and lsa_cmp
//
// usage
//   req channel: op (assign, release, clear) and buffer_id, taken on valid && ready
//   rsp channel: slot, outcome and evicted_id, one response for each request
//   except the unused op code, which is taken and dropped without a response
//   assign and release scan the slot table one slot per cycle through the
//   shared compare unit, and the final step then loads the response register;
//   ready stays low from acceptance until the final step is done, so a new
//   request is only taken once the previous one is through; the scan over the
//   single read port of the slot store sets the pace of assign and release
//   clear goes straight to the final step, which loads its response, and the
//   next request is taken after that; ready is high only while the sequencer is idle
//   the response sits in an output register: a new request is taken while it
//   waits, and a finished request holds in its final step until the receiver
//   has taken the previous response
//   reset empties every slot at once through the occupied flags and zeroes the
//   use counter; owner and stamp storage needs no clearing pass
module lru_slot_allocator import lsa_pkg::*; #(
   parameter int SLOT_COUNT = 16
) (
   input  logic      clock,
   input  logic      reset,
   lsa_req_if.sink   req,
   lsa_rsp_if.source rsp
);

   localparam int IDX_W   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int ENTRY_W = ID_W + STAMP_W;

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_type;

   // sequencer and request registers
   state_type              state_ff, state_in;
   logic [OP_W-1:0]        op_ff, op_in;
   logic [ID_W-1:0]        id_ff, id_in;
   logic [STAMP_W-1:0]     count_ff, count_in;
   logic [IDX_W-1:0]       chk_idx_ff, chk_idx_in;
   logic [SLOT_COUNT-1:0]  valid_ff, valid_in;

   // scan trackers
   logic                   hit_found_ff, hit_found_in;
   logic [IDX_W-1:0]       hit_idx_ff, hit_idx_in;
   logic                   free_found_ff, free_found_in;
   logic [IDX_W-1:0]       free_idx_ff, free_idx_in;
   logic                   old_found_ff, old_found_in;
   logic [IDX_W-1:0]       old_idx_ff, old_idx_in;
   logic [STAMP_W-1:0]     old_stamp_ff, old_stamp_in;
   logic [ID_W-1:0]        old_owner_ff, old_owner_in;

   // response register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0]      rsp_slot_ff, rsp_slot_in;
   logic [OUTCOME_W-1:0]   rsp_outcome_ff, rsp_outcome_in;
   logic [ID_W-1:0]        rsp_evicted_ff, rsp_evicted_in;

   // slot store and compare unit
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   logic [ENTRY_W-1:0]     wr_data;
   logic [IDX_W-1:0]       rd_addr;
   logic [ENTRY_W-1:0]     rd_data;
   logic [ID_W-1:0]        entry_owner;
   logic [STAMP_W-1:0]     entry_stamp;
   cmp_res_type            cmp_res;

   logic                   req_accept;
   logic                   scan_last;
   logic [IDX_W-1:0]       slot_sel;
   logic [IDX_W+SLOT_W-1:0] slot_ext;

   // each entry holds {owner id, last-use stamp}
   lsa_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOT_COUNT)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign entry_owner = rd_data[ENTRY_W-1:STAMP_W];
   assign entry_stamp = rd_data[STAMP_W-1:0];

   lsa_cmp u_cmp (
      .entry_owner (entry_owner),
      .entry_stamp (entry_stamp),
      .key_id      (id_ff),
      .best_stamp  (old_stamp_ff),
      .res         (cmp_res)
   );

   assign req.ready      = (state_ff == ST_IDLE);
   assign req_accept     = req.valid && req.ready;
   assign scan_last      = (chk_idx_ff == IDX_W'(SLOT_COUNT - 1));

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.slot       = rsp_slot_ff;
   assign rsp.outcome    = rsp_outcome_ff;
   assign rsp.evicted_id = rsp_evicted_ff;

   // slot reported in the response; zero for release miss and clear
   always_comb begin
      slot_sel = '0;
      if (hit_found_ff) begin
         slot_sel = hit_idx_ff;
      end else if (op_ff == OP_ASSIGN) begin
         slot_sel = free_found_ff ? free_idx_ff : old_idx_ff;
      end
   end

   // slot field is the low bits of the index, zero extended when narrower
   assign slot_ext = {{SLOT_W{1'b0}}, slot_sel};

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      id_in          = id_ff;
      count_in       = count_ff;
      chk_idx_in     = chk_idx_ff;
      valid_in       = valid_ff;
      hit_found_in   = hit_found_ff;
      hit_idx_in     = hit_idx_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      old_found_in   = old_found_ff;
      old_idx_in     = old_idx_ff;
      old_stamp_in   = old_stamp_ff;
      old_owner_in   = old_owner_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp.ready;
      rsp_slot_in    = rsp_slot_ff;
      rsp_outcome_in = rsp_outcome_ff;
      rsp_evicted_in = rsp_evicted_ff;
      rd_addr        = '0;
      wr_en          = 1'b0;
      wr_addr        = hit_idx_ff;
      wr_data        = {id_ff, count_ff};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               op_in         = req.op;
               id_in         = req.buffer_id;
               chk_idx_in    = '0;
               hit_found_in  = 1'b0;
               free_found_in = 1'b0;
               old_found_in  = 1'b0;
               // slot 0 read is issued now and seen in the first scan step
               priority if (req.op == OP_ASSIGN) begin
                  count_in = count_ff + 1'b1;
                  state_in = ST_SCAN;
               end else if (req.op == OP_RELEASE) begin
                  state_in = ST_SCAN;
               end else if (req.op == OP_CLEAR) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end

         ST_SCAN: begin
            rd_addr    = scan_last ? '0 : chk_idx_ff + 1'b1;
            chk_idx_in = rd_addr;
            if (valid_ff[chk_idx_ff]) begin
               if (cmp_res.id_match) begin
                  if (!hit_found_ff) begin
                     hit_found_in = 1'b1;
                     hit_idx_in   = chk_idx_ff;
                  end
               end else if (!old_found_ff || cmp_res.older) begin
                  // strict compare keeps the lowest index among equal stamps
                  old_found_in = 1'b1;
                  old_idx_in   = chk_idx_ff;
                  old_stamp_in = entry_stamp;
                  old_owner_in = entry_owner;
               end
            end else if (!free_found_ff) begin
               free_found_in = 1'b1;
               free_idx_in   = chk_idx_ff;
            end
            if (scan_last) begin
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            // wait here until the response register can take the result
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_slot_in    = slot_ext[SLOT_W-1:0];
               rsp_evicted_in = '0;
               state_in       = ST_IDLE;
               priority if (op_ff == OP_ASSIGN) begin
                  wr_en = 1'b1;
                  priority if (hit_found_ff) begin
                     wr_addr        = hit_idx_ff;
                     rsp_outcome_in = OUT_HIT;
                  end else if (free_found_ff) begin
                     wr_addr               = free_idx_ff;
                     valid_in[free_idx_ff] = 1'b1;
                     rsp_outcome_in        = OUT_FILLED;
                  end else begin
                     wr_addr        = old_idx_ff;
                     rsp_outcome_in = OUT_EVICTED;
                     rsp_evicted_in = old_owner_ff;
                  end
               end else if (op_ff == OP_RELEASE) begin
                  if (hit_found_ff) begin
                     valid_in[hit_idx_ff] = 1'b0;
                     rsp_outcome_in       = OUT_RELEASED;
                  end else begin
                     rsp_outcome_in = OUT_RELEASE_MISS;
                  end
               end else begin
                  valid_in       = '0;
                  count_in       = '0;
                  rsp_outcome_in = OUT_CLEARED;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         valid_ff      <= '0;
         hit_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
         old_found_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         valid_ff      <= valid_in;
         hit_found_ff  <= hit_found_in;
         free_found_ff <= free_found_in;
         old_found_ff  <= old_found_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      op_ff          <= op_in;
      id_ff          <= id_in;
      chk_idx_ff     <= chk_idx_in;
      hit_idx_ff     <= hit_idx_in;
      free_idx_ff    <= free_idx_in;
      old_idx_ff     <= old_idx_in;
      old_stamp_ff   <= old_stamp_in;
      old_owner_ff   <= old_owner_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_outcome_ff <= rsp_outcome_in;
      rsp_evicted_ff <= rsp_evicted_in;
   end

   // a full table with no hit must have found an eviction candidate
   a_victim_found: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && op_ff == OP_ASSIGN && !hit_found_ff && !free_found_ff)
      |-> old_found_ff)
      else $error("assign finished with no free slot and no victim");

   // a new response only comes out of the final sequencer step
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside the final step");

   // a clear leaves every slot empty
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_outcome_ff == OUT_CLEARED &&
       $past(state_ff == ST_DONE && op_ff == OP_CLEAR && (!rsp_valid_ff || rsp.ready)))
      |-> (valid_ff == '0 && count_ff == '0))
      else $error("slots still occupied after clear");

endmodule

/* bench/tb_top.sv */
// tb_top: self-checking bench for the lru slot allocator, covering hits, fills,
// evictions, releases and clears under random idling on both channels
// depends on lsa_pkg, lsa_if and lru_slot_allocator
`timescale 1ns / 1ps

module tb_top;
   import lsa_pkg::*;

   localparam int SLOT_COUNT = 16;
   localparam int HALF_PERIOD = 10;

   // the one op code with no name in the package: taken and dropped by the block
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam logic [ID_W-1:0] ID_MAX = {ID_W{1'b1}};

   typedef struct packed {
      logic [SLOT_W-1:0]    slot;
      logic [OUTCOME_W-1:0] outcome;
      logic [ID_W-1:0]      evicted_id;
   } slot_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lsa_req_if req_if ();
   lsa_rsp_if rsp_if ();

   lru_slot_allocator #(.SLOT_COUNT(SLOT_COUNT)) u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   always #HALF_PERIOD clock = ~clock;

   // shadow copy of the slot table
   logic [ID_W-1:0]    held_id  [SLOT_COUNT];
   logic [STAMP_W-1:0] last_use [SLOT_COUNT];
   bit                 occupied [SLOT_COUNT];
   logic [STAMP_W-1:0] use_count;

   // responses the block still owes, oldest first
   slot_rsp_type pending_rsps[$];

   int error_count    = 0;
   int requests_sent  = 0;
   int rsps_checked   = 0;
   int outcome_tally [6];

   // idling percentages for each side, and the long receiver hold-off
   int req_idle_pct    = 0;
   int rsp_idle_pct    = 0;
   int rsp_hold_cycles = 0;

   // ids the random traffic draws from, so that hits and evictions happen
   logic [ID_W-1:0] id_pool[$];

   // ------------------------------------------------------------------
   // table prediction
   // ------------------------------------------------------------------

   task automatic wipe_table();
      for (int i = 0; i < SLOT_COUNT; i++) begin
         held_id[i]  = '0;
         last_use[i] = '0;
         occupied[i] = 1'b0;
      end
      use_count = '0;
   endtask

   task automatic lru_table_apply(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                                  output bit gives_rsp, output slot_rsp_type rsp);
      int free_idx;
      int old_idx;
      free_idx  = -1;
      old_idx   = -1;
      gives_rsp = 1'b1;
      rsp       = '0;
      case (op)
         OP_ASSIGN: begin
            use_count = use_count + 1'b1;
            for (int i = 0; i < SLOT_COUNT; i++) begin
               if (!occupied[i]) begin
                  if (free_idx < 0) free_idx = i;
               end else if (held_id[i] == id) begin
                  // already held: refresh its stamp and report a hit
                  last_use[i] = use_count;
                  rsp.slot    = SLOT_W'(i);
                  rsp.outcome = OUT_HIT;
                  return;
               end else if (old_idx < 0 || last_use[i] < last_use[old_idx]) begin
                  // strict compare keeps the lowest index among equal stamps
                  old_idx = i;
               end
            end
            if (free_idx >= 0) begin
               occupied[free_idx] = 1'b1;
               held_id[free_idx]  = id;
               last_use[free_idx] = use_count;
               rsp.slot    = SLOT_W'(free_idx);
               rsp.outcome = OUT_FILLED;
            end else begin
               // table full: the least recently used slot gives way
               rsp.slot           = SLOT_W'(old_idx);
               rsp.outcome        = OUT_EVICTED;
               rsp.evicted_id     = held_id[old_idx];
               held_id[old_idx]   = id;
               last_use[old_idx]  = use_count;
            end
         end
         OP_RELEASE: begin
            rsp.outcome = OUT_RELEASE_MISS;
            for (int i = 0; i < SLOT_COUNT; i++) begin
               if (occupied[i] && held_id[i] == id) begin
                  occupied[i] = 1'b0;
                  held_id[i]  = '0;
                  last_use[i] = '0;   // counter itself is left alone
                  rsp.slot    = SLOT_W'(i);
                  rsp.outcome = OUT_RELEASED;
                  return;
               end
            end
         end
         OP_CLEAR: begin
            wipe_table();
            rsp.outcome = OUT_CLEARED;
         end
         default: begin
            gives_rsp = 1'b0;   // unused code: no state change, no response
         end
      endcase
   endtask

   // ------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------

   // offers one request, waits for the handshake, then records the expected
   // response, if any; called just after a rising edge
   task automatic send_request(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id);
      bit           gives_rsp;
      slot_rsp_type rsp;
      while ($urandom_range(99) < req_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.op        <= op;
      req_if.buffer_id <= id;
      do @(posedge clock); while (!req_if.ready);
      requests_sent++;
      lru_table_apply(op, id, gives_rsp, rsp);
      if (gives_rsp) pending_rsps.push_back(rsp);
   endtask

   task automatic end_of_burst();
      req_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // response side: checks each taken response, then decides ready
   // ------------------------------------------------------------------

   task automatic check_response();
      slot_rsp_type exp;
      if (pending_rsps.size() == 0) begin
         $display("%0t: unexpected response, expected none, actual slot %0d outcome %0d id %0h",
                  $time, rsp_if.slot, rsp_if.outcome, rsp_if.evicted_id);
         error_count++;
         return;
      end
      exp = pending_rsps.pop_front();
      rsps_checked++;
      if (rsp_if.slot !== exp.slot) begin
         $display("%0t: slot mismatch, expected %0d, actual %0d",
                  $time, exp.slot, rsp_if.slot);
         error_count++;
      end
      if (rsp_if.outcome !== exp.outcome) begin
         $display("%0t: outcome mismatch, expected %0d, actual %0d",
                  $time, exp.outcome, rsp_if.outcome);
         error_count++;
      end
      if (rsp_if.evicted_id !== exp.evicted_id) begin
         $display("%0t: evicted id mismatch, expected %0h, actual %0h",
                  $time, exp.evicted_id, rsp_if.evicted_id);
         error_count++;
      end
      if (exp.outcome <= OUT_CLEARED) outcome_tally[exp.outcome]++;
   endtask

   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) check_response();
         // long hold-off is counted down here, on each edge
         if (rsp_hold_cycles > 0) begin
            rsp_hold_cycles--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // release and unused op against an empty table
   task automatic test_empty_table();
      send_request(OP_RELEASE, '0);
      send_request(OP_UNUSED, ID_MAX);
      end_of_burst();
   endtask

   // fills every slot, refreshes the first, then forces two evictions
   logic [ID_W-1:0] fill_ids [SLOT_COUNT];

   task automatic test_fill_and_evict();
      for (int i = 0; i < SLOT_COUNT; i++) begin
         // distinct top bits keep the ids apart, extremes at both ends
         if (i == 0) fill_ids[i] = '0;
         else if (i == SLOT_COUNT - 1) fill_ids[i] = ID_MAX;
         else fill_ids[i] = {4'(i), 27'($urandom)};
         send_request(OP_ASSIGN, fill_ids[i]);
      end
      send_request(OP_ASSIGN, fill_ids[0]);          // hit, slot 0 now newest
      send_request(OP_ASSIGN, 31'h2AAAAAAA);         // evicts slot 1
      send_request(OP_ASSIGN, 31'h55555555);         // evicts slot 2
      end_of_burst();
   endtask

   // freeing a slot, refilling it, the unused code, and a full clear
   task automatic test_release_and_clear();
      send_request(OP_RELEASE, fill_ids[7]);
      send_request(OP_ASSIGN, 31'h12345678);         // lowest free slot again
      send_request(OP_RELEASE, fill_ids[7]);         // now absent
      send_request(OP_UNUSED, fill_ids[3]);
      send_request(OP_ASSIGN, fill_ids[3]);          // still a hit
      send_request(OP_CLEAR, ID_MAX);
      send_request(OP_RELEASE, fill_ids[3]);         // gone after the clear
      send_request(OP_ASSIGN, fill_ids[3]);          // lands in slot 0
      end_of_burst();
   endtask

   task automatic build_id_pool(input int pool_size);
      id_pool.delete();
      for (int i = 0; i < pool_size; i++) id_pool.push_back(ID_W'($urandom));
   endtask

   function automatic logic [ID_W-1:0] pick_id();
      // mostly pool ids for hits and churn, now and then a stray one
      if ($urandom_range(9) == 0) return ID_W'($urandom);
      return id_pool[$urandom_range(id_pool.size() - 1)];
   endfunction

   task automatic test_random_traffic(input int n_items, input int pool_size,
                                      input int req_pct, input int rsp_pct);
      int roll;
      req_idle_pct = req_pct;
      rsp_idle_pct = rsp_pct;
      build_id_pool(pool_size);
      for (int n = 0; n < n_items; n++) begin
         roll = $urandom_range(99);
         if (roll < 68) send_request(OP_ASSIGN, pick_id());
         else if (roll < 93) send_request(OP_RELEASE, pick_id());
         else if (roll < 97) send_request(OP_CLEAR, ID_W'($urandom));
         else send_request(OP_UNUSED, ID_W'($urandom));
      end
      end_of_burst();
   endtask

   // receiver stops for a long stretch while requests keep coming
   task automatic test_stalled_output();
      req_idle_pct    = 0;
      rsp_idle_pct    = 0;
      rsp_hold_cycles = 400;
      build_id_pool(12);
      for (int n = 0; n < 24; n++) begin
         if (n % 5 == 4) send_request(OP_RELEASE, pick_id());
         else send_request(OP_ASSIGN, pick_id());
      end
      end_of_burst();
   endtask

   // ------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------

   initial begin
      req_if.valid     <= 1'b0;
      req_if.op        <= OP_ASSIGN;
      req_if.buffer_id <= '0;
      wipe_table();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_table();
      test_fill_and_evict();
      test_release_and_clear();
      test_random_traffic(580, 24, 18, 66);
      test_stalled_output();
      test_random_traffic(580, 20, 66, 18);
      test_random_traffic(590, 28, 0, 0);

      // drain, then allow for anything the block might still send
      rsp_idle_pct = 0;
      while (pending_rsps.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("tb: %0d requests, %0d responses checked", requests_sent, rsps_checked);
      $display("tb: hits %0d, fills %0d, evictions %0d, releases %0d, misses %0d, clears %0d",
               outcome_tally[OUT_HIT], outcome_tally[OUT_FILLED], outcome_tally[OUT_EVICTED],
               outcome_tally[OUT_RELEASED], outcome_tally[OUT_RELEASE_MISS],
               outcome_tally[OUT_CLEARED]);
      if (error_count == 0 && pending_rsps.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #50_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

/* sim.f */
rtl/core/lsa_pkg.sv
rtl/core/lsa_if.sv
rtl/core/lsa_ram.sv
rtl/core/lsa_cmp.sv
rtl/core/lru_slot_allocator.sv
bench/tb_top.sv
